### hw/rtl/sqn_pkg.sv
package sqn_pkg;

    localparam int NEWTON_STEPS_DEF = 3;

    localparam logic [31:0] MAGIC_SEED = 32'h5F3759DF;
    localparam logic [31:0] F_ONE_HALF = 32'h3FC00000;
    localparam logic [31:0] F_HALF     = 32'h3F000000;
    localparam logic [31:0] F_QNAN     = 32'h7FC00000;
    localparam logic [31:0] F_INF      = 32'h7F800000;
    localparam logic [31:0] F_SIGN     = 32'h80000000;
    localparam logic [31:0] F_ZERO     = 32'h00000000;

    // Significand datapath into the rounder: 1 carry bit, 24 mantissa bits,
    // GUARD_W bits below the mantissa for alignment and rounding.
    localparam int GUARD_W = 26;
    localparam int SIG_W   = 1 + 24 + GUARD_W;
    localparam int LZ_W    = $clog2(SIG_W + 1);
    localparam int SCALE_W = 10;

    typedef enum logic [2:0] {
        OP_HALF,
        OP_HY,
        OP_TY,
        OP_SUB,
        OP_YT,
        OP_FINAL
    } op_kind_t;

    // Context that travels with each word down the whole pipe.
    typedef struct packed {
        logic [31:0] x;
        logic [31:0] half;
        logic [31:0] y;
        logic        zero;
    } ctx_t;

    // Unrounded result: sign * sig * 2^scale, or a finished special value.
    typedef struct packed {
        logic                      spec;
        logic [31:0]               spec_bits;
        logic                      sign;
        logic signed [SCALE_W-1:0] scale;
        logic [SIG_W-1:0]          sig;
    } rnd_t;

    function automatic logic is_nan(input logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [31:0] v);
        return v[30:0] == F_INF[30:0];
    endfunction

    function automatic logic is_zero(input logic [31:0] v);
        return v[30:0] == 31'd0;
    endfunction

endpackage

### hw/rtl/sqn_round.sv
module sqn_round
    import sqn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  rnd_t        in_rnd,
    input  ctx_t        in_ctx,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] out_bits,
    output ctx_t        out_ctx
);

    // Stage B: leading-zero count and normalizing shift.
    logic                      b_valid_reg;
    logic                      b_spec_reg;
    logic [31:0]               b_spec_bits_reg;
    logic                      b_sign_reg;
    logic signed [SCALE_W-1:0] b_be_reg;
    logic [SIG_W-1:0]          b_norm_reg;
    ctx_t                      b_ctx_reg;

    // Stage C: denormal shift and rounding.
    logic                      c_valid_reg;
    logic [31:0]               c_bits_reg;
    ctx_t                      c_ctx_reg;

    logic                      b_ready;
    logic                      c_ready;
    logic [LZ_W-1:0]           lz;
    logic signed [SCALE_W-1:0] be_next;
    logic [SIG_W-1:0]          norm_next;

    logic                      over;
    logic                      norm_exp;
    logic signed [SCALE_W-1:0] dwide;
    logic [LZ_W-1:0]           dsh;
    logic [SIG_W-1:0]          shifted;
    logic                      lost;
    logic [23:0]               mant;
    logic                      guard;
    logic                      sticky;
    logic                      up;
    logic [24:0]               mant_rnd;
    logic [31:0]               exp_field;
    logic [31:0]               bits;
    logic [31:0]               bits_next;

    assign c_ready  = !c_valid_reg || !out_stall;
    assign b_ready  = !b_valid_reg || c_ready;
    assign in_stall = !b_ready;

    always_comb
    begin
        lz = LZ_W'(SIG_W);
        for (int i = 0; i < SIG_W; i++)
        begin
            if (in_rnd.sig[i])
            begin
                lz = LZ_W'(SIG_W - 1 - i);
            end
        end
    end

    assign norm_next = in_rnd.sig << lz;
    assign be_next   = in_rnd.scale + $signed(SCALE_W'(SIG_W + 126))
                       - $signed(SCALE_W'(lz));

    always_comb
    begin
        over     = b_be_reg >= $signed(SCALE_W'(255));
        norm_exp = b_be_reg >= $signed(SCALE_W'(1));
        dwide    = $signed(SCALE_W'(1)) - b_be_reg;
        if (norm_exp)
        begin
            dsh = '0;
        end
        else if (dwide > $signed(SCALE_W'(SIG_W)))
        begin
            dsh = LZ_W'(SIG_W);
        end
        else
        begin
            dsh = dwide[LZ_W-1:0];
        end
        shifted   = b_norm_reg >> dsh;
        lost      = (shifted << dsh) != b_norm_reg;
        mant      = shifted[SIG_W-1 -: 24];
        guard     = shifted[SIG_W-25];
        sticky    = (|shifted[SIG_W-26:0]) || lost;
        up        = guard && (sticky || mant[0]);
        mant_rnd  = {1'b0, mant} + 25'(up);
        exp_field = norm_exp ? {1'b0, 8'(b_be_reg - $signed(SCALE_W'(1))), 23'd0} : 32'd0;
        bits      = exp_field + 32'(mant_rnd);
        if (b_spec_reg)
        begin
            bits_next = b_spec_bits_reg;
        end
        else if (over || bits >= F_INF)
        begin
            bits_next = {b_sign_reg, F_INF[30:0]};
        end
        else
        begin
            bits_next = {b_sign_reg, bits[30:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (b_ready)
            begin
                b_valid_reg <= in_valid;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready)
        begin
            b_spec_reg      <= in_rnd.spec;
            b_spec_bits_reg <= in_rnd.spec_bits;
            b_sign_reg      <= in_rnd.sign;
            b_be_reg        <= be_next;
            b_norm_reg      <= norm_next;
            b_ctx_reg       <= in_ctx;
        end
        if (c_ready)
        begin
            c_bits_reg <= bits_next;
            c_ctx_reg  <= b_ctx_reg;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_bits  = c_bits_reg;
    assign out_ctx   = c_ctx_reg;

endmodule

### hw/rtl/sqn_fmul.sv
module sqn_fmul
    import sqn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  ctx_t        in_ctx,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] r,
    output ctx_t        out_ctx
);

    logic        a_valid_reg;
    rnd_t        a_rnd_reg;
    ctx_t        a_ctx_reg;
    rnd_t        a_rnd_next;
    logic        a_ready;
    logic        rnd_stall;
    logic        s;
    logic [23:0] ma;
    logic [23:0] mb;
    logic [7:0]  ea;
    logic [7:0]  eb;
    logic [47:0] prod;

    assign a_ready  = !a_valid_reg || !rnd_stall;
    assign in_stall = !a_ready;

    always_comb
    begin
        s    = a[31] ^ b[31];
        ma   = {|a[30:23], a[22:0]};
        mb   = {|b[30:23], b[22:0]};
        ea   = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb   = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        prod = ma * mb;
        a_rnd_next.sign  = s;
        a_rnd_next.sig   = SIG_W'(prod);
        a_rnd_next.scale = $signed(SCALE_W'(ea)) + $signed(SCALE_W'(eb))
                           - $signed(SCALE_W'(300));
        a_rnd_next.spec      = 1'b1;
        a_rnd_next.spec_bits = F_QNAN;
        if (is_nan(a) || is_nan(b))
        begin
            a_rnd_next.spec_bits = F_QNAN;
        end
        else if (is_inf(a) || is_inf(b))
        begin
            a_rnd_next.spec_bits = (is_zero(a) || is_zero(b)) ? F_QNAN
                                                            : {s, F_INF[30:0]};
        end
        else if (is_zero(a) || is_zero(b))
        begin
            a_rnd_next.spec_bits = {s, 31'd0};
        end
        else
        begin
            a_rnd_next.spec = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready)
        begin
            a_rnd_reg <= a_rnd_next;
            a_ctx_reg <= in_ctx;
        end
    end

    sqn_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_valid_reg),
        .in_stall  (rnd_stall),
        .in_rnd    (a_rnd_reg),
        .in_ctx    (a_ctx_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_bits  (r),
        .out_ctx   (out_ctx)
    );

endmodule

### hw/rtl/sqn_fadd.sv
module sqn_fadd
    import sqn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  ctx_t        in_ctx,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] r,
    output ctx_t        out_ctx
);

    logic             a_valid_reg;
    rnd_t             a_rnd_reg;
    ctx_t             a_ctx_reg;
    rnd_t             a_rnd_next;
    logic             a_ready;
    logic             rnd_stall;
    logic [23:0]      ma;
    logic [23:0]      mb;
    logic [7:0]       ea;
    logic [7:0]       eb;
    logic             swap;
    logic [23:0]      m_big;
    logic [23:0]      m_sml;
    logic [7:0]       e_big;
    logic [7:0]       d;
    logic             s_big;
    logic             s_sml;
    logic [SIG_W-1:0] xa;
    logic [SIG_W-1:0] y0;
    logic [SIG_W-1:0] ysh;
    logic [SIG_W-1:0] ya;

    assign a_ready  = !a_valid_reg || !rnd_stall;
    assign in_stall = !a_ready;

    always_comb
    begin
        ma    = {|a[30:23], a[22:0]};
        mb    = {|b[30:23], b[22:0]};
        ea    = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb    = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        swap  = eb > ea;
        m_big = swap ? mb : ma;
        m_sml = swap ? ma : mb;
        e_big = swap ? eb : ea;
        s_big = swap ? b[31] : a[31];
        s_sml = swap ? a[31] : b[31];
        d     = swap ? (eb - ea) : (ea - eb);
        xa    = {1'b0, m_big, GUARD_W'(0)};
        y0    = {1'b0, m_sml, GUARD_W'(0)};
        ysh   = y0 >> d;
        // Bits shifted out of the smaller operand collapse into a sticky bit.
        ya    = ysh | SIG_W'((ysh << d) != y0);

        a_rnd_next.scale     = $signed(SCALE_W'(e_big)) - $signed(SCALE_W'(150 + GUARD_W));
        a_rnd_next.sign      = s_big;
        a_rnd_next.sig       = xa + ya;
        a_rnd_next.spec      = 1'b1;
        a_rnd_next.spec_bits = F_QNAN;
        if (is_nan(a) || is_nan(b))
        begin
            a_rnd_next.spec_bits = F_QNAN;
        end
        else if (is_inf(a) && is_inf(b))
        begin
            a_rnd_next.spec_bits = (a[31] != b[31]) ? F_QNAN : a;
        end
        else if (is_inf(a))
        begin
            a_rnd_next.spec_bits = a;
        end
        else if (is_inf(b))
        begin
            a_rnd_next.spec_bits = b;
        end
        else if (is_zero(a) && is_zero(b))
        begin
            a_rnd_next.spec_bits = {a[31] & b[31], 31'd0};
        end
        else if (is_zero(a))
        begin
            a_rnd_next.spec_bits = b;
        end
        else if (is_zero(b))
        begin
            a_rnd_next.spec_bits = a;
        end
        else if (s_big == s_sml)
        begin
            a_rnd_next.spec = 1'b0;
        end
        else if (xa > ya)
        begin
            a_rnd_next.spec = 1'b0;
            a_rnd_next.sig  = xa - ya;
        end
        else if (ya > xa)
        begin
            a_rnd_next.spec = 1'b0;
            a_rnd_next.sign = s_sml;
            a_rnd_next.sig  = ya - xa;
        end
        else
        begin
            // Exact cancellation gives positive zero.
            a_rnd_next.spec_bits = F_ZERO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready)
        begin
            a_rnd_reg <= a_rnd_next;
            a_ctx_reg <= in_ctx;
        end
    end

    sqn_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_valid_reg),
        .in_stall  (rnd_stall),
        .in_rnd    (a_rnd_reg),
        .in_ctx    (a_ctx_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_bits  (r),
        .out_ctx   (out_ctx)
    );

endmodule

### hw/rtl/newton_float_square_root.sv
// Approximate single-precision square root: the bit-trick reciprocal-root seed is refined by
// NEWTON_STEPS Newton steps and multiplied by x; inputs that compare <= 0 give +0. The pipe is
// a chain of 4*NEWTON_STEPS+2 floating-point operations, each three register stages deep
// (operand stage, normalize stage, round stage); one word is accepted every cycle unless the
// pipe is held full by root_stall. Every stage has its own valid bit, so a stall on root_stall
// fills empty stages first and x_stall rises only when the pipe is full.
module newton_float_square_root
    import sqn_pkg::*;
#(
    parameter int NEWTON_STEPS = NEWTON_STEPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        x_valid,
    output logic        x_stall,
    input  logic [31:0] x_bits,
    output logic        root_valid,
    input  logic        root_stall,
    output logic [31:0] root_bits
);

    localparam int NOPS = 4 * NEWTON_STEPS + 2;

    function automatic op_kind_t op_kind_of(input int k);
        op_kind_t kind;
        if (k == 0)
        begin
            kind = OP_HALF;
        end
        else if (k == NOPS - 1)
        begin
            kind = OP_FINAL;
        end
        else
        begin
            unique case ((k - 1) % 4)
                0:       kind = OP_HY;
                1:       kind = OP_TY;
                2:       kind = OP_SUB;
                default: kind = OP_YT;
            endcase
        end
        return kind;
    endfunction

    logic        iv [NOPS];
    logic        is [NOPS];
    logic [31:0] ia [NOPS];
    logic [31:0] ib [NOPS];
    ctx_t        ic [NOPS];
    logic        ov [NOPS];
    logic        os [NOPS];
    logic [31:0] orr[NOPS];
    ctx_t        oc [NOPS];

    for (genvar k = 0; k < NOPS; k++)
    begin : g_op
        localparam op_kind_t KIND = op_kind_of(k);

        if (k == 0)
        begin : g_entry
            assign iv[k]      = x_valid;
            assign ic[k].x    = x_bits;
            assign ic[k].half = F_ZERO;
            assign ic[k].y    = MAGIC_SEED - (x_bits >> 1);
            assign ic[k].zero = !is_nan(x_bits) && (x_bits[31] || x_bits == F_ZERO);
        end
        else
        begin : g_link
            localparam op_kind_t PREV = op_kind_of(k - 1);
            assign iv[k-1 + 1] = ov[k-1];
            assign os[k-1]     = is[k];
            always_comb
            begin
                ic[k] = oc[k-1];
                if (PREV == OP_HALF)
                begin
                    ic[k].half = orr[k-1];
                end
                else if (PREV == OP_YT)
                begin
                    ic[k].y = orr[k-1];
                end
            end
        end

        always_comb
        begin
            unique case (KIND)
                OP_HALF:
                begin
                    ia[k] = F_HALF;
                    ib[k] = ic[k].x;
                end
                OP_HY:
                begin
                    ia[k] = ic[k].half;
                    ib[k] = ic[k].y;
                end
                OP_TY:
                begin
                    ia[k] = orr[(k > 0) ? k - 1 : 0];
                    ib[k] = ic[k].y;
                end
                OP_SUB:
                begin
                    ia[k] = F_ONE_HALF;
                    ib[k] = orr[(k > 0) ? k - 1 : 0] ^ F_SIGN;
                end
                OP_YT:
                begin
                    ia[k] = ic[k].y;
                    ib[k] = orr[(k > 0) ? k - 1 : 0];
                end
                default:
                begin
                    ia[k] = ic[k].x;
                    ib[k] = ic[k].y;
                end
            endcase
        end

        if (KIND == OP_SUB)
        begin : g_sub
            sqn_fadd u_fadd (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (iv[k]),
                .in_stall  (is[k]),
                .a         (ia[k]),
                .b         (ib[k]),
                .in_ctx    (ic[k]),
                .out_valid (ov[k]),
                .out_stall (os[k]),
                .r         (orr[k]),
                .out_ctx   (oc[k])
            );
        end
        else
        begin : g_mul
            sqn_fmul u_fmul (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (iv[k]),
                .in_stall  (is[k]),
                .a         (ia[k]),
                .b         (ib[k]),
                .in_ctx    (ic[k]),
                .out_valid (ov[k]),
                .out_stall (os[k]),
                .r         (orr[k]),
                .out_ctx   (oc[k])
            );
        end
    end

    assign x_stall      = is[0];
    assign root_valid   = ov[NOPS-1];
    assign os[NOPS-1]   = root_stall;
    assign root_bits    = oc[NOPS-1].zero ? F_ZERO : orr[NOPS-1];

    // The input can only be held off when every stage is full and the output is blocked.
    a_stall_chain: assert property (@(posedge clk) disable iff (!rst_n)
        x_stall |-> (root_valid && root_stall))
        else $error("input stalled while the pipe still has room");

    // The zero flag must still match the operand it was computed from.
    a_zero_ctx: assert property (@(posedge clk) disable iff (!rst_n)
        (root_valid && oc[NOPS-1].zero) |->
            (oc[NOPS-1].x[31] || oc[NOPS-1].x[30:0] == 31'd0))
        else $error("zero flag separated from its operand");

    // A NaN operand propagates as the canonical quiet NaN.
    a_nan_out: assert property (@(posedge clk) disable iff (!rst_n)
        (root_valid && is_nan(oc[NOPS-1].x)) |-> (root_bits == F_QNAN))
        else $error("NaN operand did not give the quiet NaN");

endmodule

### tb/newton_float_square_root_tb.sv
module newton_float_square_root_tb;
    import sqn_pkg::*;

    localparam int LATENCY   = 12 * NEWTON_STEPS_DEF + 6;
    localparam int N_RANDOM  = 1900;
    localparam int MAX_CYCLES = 400000;

    // Bit-exact single-precision arithmetic used to predict the root.
    function automatic bit fp_is_nan(logic [31:0] v);
        return v[30:23] == 8'hFF && v[22:0] != 0;
    endfunction

    function automatic bit fp_is_inf(logic [31:0] v);
        return v[30:0] == 31'h7F800000;
    endfunction

    function automatic void fp_unpack(logic [31:0] v, output logic [63:0] m,
                                      output int e);
        if (v[30:23] == 0)
        begin
            m = {41'd0, v[22:0]};
            e = 1;
        end
        else
        begin
            m = {40'd0, 1'b1, v[22:0]};
            e = int'(v[30:23]);
        end
    endfunction

    function automatic logic [31:0] fp_round(logic [31:0] s, int scale, logic [63:0] sig);
        int n, be, sh;
        logic [63:0] m, bits, mask, rem, half;
        n = 0;
        while (n < 63 && (sig >> (n + 1)) != 0) n++;
        be = n + scale + 127;
        if (be >= 255) return s | 32'h7F800000;
        sh = (be >= 1) ? n - 23 : -149 - scale;
        if (sh <= 0)
            m = sig << (-sh);
        else if (sh > 64)
            m = 0;
        else
        begin
            mask = (sh < 64) ? ((64'd1 << sh) - 1) : ~64'd0;
            rem = sig & mask;
            half = 64'd1 << (sh - 1);
            m = (sh < 64) ? (sig >> sh) : 0;
            if (rem > half || (rem == half && m[0])) m++;
        end
        bits = (be >= 1) ? ((64'(be - 1) << 23) + m) : m;
        if (bits >= 64'h7F800000) return s | 32'h7F800000;
        return s | bits[31:0];
    endfunction

    function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
        logic [31:0] s;
        logic [63:0] ma, mb;
        int ea, eb;
        bit za, zb;
        s = (a ^ b) & 32'h80000000;
        za = a[30:0] == 0;
        zb = b[30:0] == 0;
        if (fp_is_nan(a) || fp_is_nan(b)) return 32'h7FC00000;
        if (fp_is_inf(a) || fp_is_inf(b)) return (za || zb) ? 32'h7FC00000 : (s | 32'h7F800000);
        if (za || zb) return s;
        fp_unpack(a, ma, ea);
        fp_unpack(b, mb, eb);
        return fp_round(s, ea + eb - 300, ma * mb);
    endfunction

    function automatic logic [63:0] sticky_shift(logic [63:0] m, int t);
        if (t >= 64) return 1;
        return (m >> t) | 64'((m & ((64'd1 << t) - 1)) != 0);
    endfunction

    function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
        logic [31:0] sa, sb;
        logic [63:0] ma, mb, x, y, r;
        int ea, eb, scale, d;
        sa = a & 32'h80000000;
        sb = b & 32'h80000000;
        if (fp_is_nan(a) || fp_is_nan(b)) return 32'h7FC00000;
        if (fp_is_inf(a) && fp_is_inf(b)) return (sa != sb) ? 32'h7FC00000 : a;
        if (fp_is_inf(a)) return a;
        if (fp_is_inf(b)) return b;
        if (a[30:0] == 0 && b[30:0] == 0) return sa & sb;
        if (a[30:0] == 0) return b;
        if (b[30:0] == 0) return a;
        fp_unpack(a, ma, ea);
        fp_unpack(b, mb, eb);
        if (ea >= eb)
        begin
            d = ea - eb;
            if (d <= 39)
            begin
                x = ma << d; y = mb; scale = eb - 150;
            end
            else
            begin
                x = ma << 39; y = sticky_shift(mb, d - 39); scale = ea - 189;
            end
        end
        else
        begin
            d = eb - ea;
            if (d <= 39)
            begin
                y = mb << d; x = ma; scale = ea - 150;
            end
            else
            begin
                y = mb << 39; x = sticky_shift(ma, d - 39); scale = eb - 189;
            end
        end
        if (sa == sb) return fp_round(sa, scale, x + y);
        if (x > y) return fp_round(sa, scale, x - y);
        if (y > x) return fp_round(sb, scale, y - x);
        return 32'd0;
    endfunction

    function automatic logic [31:0] predict_root(logic [31:0] x);
        logic [31:0] y, half, t;
        if (!fp_is_nan(x) && (x[31] || x == 0)) return F_ZERO;
        y = MAGIC_SEED - (x >> 1);
        half = fp_mul(F_HALF, x);
        for (int i = 0; i < NEWTON_STEPS_DEF; i++)
        begin
            t = fp_mul(fp_mul(half, y), y);
            t = fp_add(F_ONE_HALF, t ^ F_SIGN);
            y = fp_mul(y, t);
        end
        return fp_mul(x, y);
    endfunction

    class root_scoreboard;
        logic [31:0] pending_roots[$];
        int errors;
        int checked;

        function void note_operand(logic [31:0] x);
            pending_roots.push_back(predict_root(x));
        endfunction

        function void check_root(logic [31:0] got);
            logic [31:0] want;
            if (pending_roots.size() == 0)
            begin
                $error("root_bits: unexpected word, expected none, actual %h", got);
                errors++;
                return;
            end
            want = pending_roots.pop_front();
            checked++;
            if (got !== want)
            begin
                $error("root_bits: expected %h, actual %h", want, got);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        x_valid = 0;
    logic        x_stall;
    logic [31:0] x_bits = 0;
    logic        root_valid;
    logic        root_stall = 0;
    logic [31:0] root_bits;

    root_scoreboard sb = new();
    int  cycle = 0;
    bit  calm = 0;
    int  sent = 0;

    newton_float_square_root dut (
        .clk(clk), .rst_n(rst_n),
        .x_valid(x_valid), .x_stall(x_stall), .x_bits(x_bits),
        .root_valid(root_valid), .root_stall(root_stall), .root_bits(root_bits)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        if (rst_n && x_valid && !x_stall) sb.note_operand(x_bits);
        if (rst_n && root_valid && !root_stall) sb.check_root(root_bits);
    end

    // The receiver stalls at random, except during the calm stretch.
    always @(negedge clk)
        root_stall <= rst_n && !calm && ($urandom_range(99) < 23);

    // Presents one word, with an optional idle gap before it, and holds it until taken.
    task automatic send_word(logic [31:0] x);
        while (!calm && $urandom_range(99) < 23)
        begin
            x_valid <= 0;
            @(negedge clk);
        end
        x_valid <= 1;
        x_bits <= x;
        @(posedge clk);
        while (x_stall) @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    task automatic drain;
        x_valid <= 0;
        while (sb.pending_roots.size() != 0) @(negedge clk);
    endtask

    function automatic logic [31:0] random_operand;
        case ($urandom_range(9))
            0: return $urandom();
            1: return {1'b0, 8'd0, 23'($urandom())};
            2: return {1'b0, 8'hFF, 23'($urandom())};
            3: return {1'b1, 31'($urandom())};
            4: return {1'b0, 8'($urandom_range(250, 254)), 23'($urandom())};
            5: return {1'b0, 8'($urandom_range(1, 5)), 23'($urandom())};
            default: return {1'b0, 31'($urandom())};
        endcase
    endfunction

    localparam logic [31:0] DIRECTED[20] = '{
        32'h00000000, 32'h80000000, 32'h3F800000, 32'h40800000, 32'h40000000,
        32'h00000001, 32'h007FFFFF, 32'h00800000, 32'h7F7FFFFF, 32'h7F800000,
        32'hFF800000, 32'h7FC00000, 32'h7F800001, 32'hFFFFFFFF, 32'hBF800000,
        32'h3E800000, 32'h42C80000, 32'h00400000, 32'h7FFFFFFF, 32'h80000001
    };

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);
        foreach (DIRECTED[i]) send_word(DIRECTED[i]);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            calm = (i >= 600 && i < 800);
            if (i == 1000) drain();
            send_word(random_operand());
        end
        calm = 0;
        drain();
        repeat (LATENCY + 10) @(negedge clk);
        $display("Sent %0d operands (zeros, signs, subnormals, infinities, NaNs, random).",
                 sent);
        $display("Checked %0d roots with %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending_roots.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
